[hw/rtl/particle_swarm_update_2d_unit_defines.svh]
// Assertion macros for the particle swarm update unit.
`ifndef PARTICLE_SWARM_UPDATE_2D_UNIT_DEFINES_SVH
`define PARTICLE_SWARM_UPDATE_2D_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PSU2D_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PSU2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/psu2d_pkg.sv]
// Shared types, constants and helpers for the particle swarm update unit.
package psu2d_pkg;

  localparam int PARTICLE_COUNT = 64;
  localparam int PIDX_W         = 6;
  localparam int CFG_IDX_W      = 3;

  localparam logic [31:0] NO_BEST      = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_MIN_RST  = 32'h8000_0000;
  localparam logic [31:0] POS_MAX_RST  = 32'h7FFF_FFFF;
  localparam logic [15:0] INERTIA_RST  = 16'd2867;
  localparam logic [15:0] PERSONAL_RST = 16'd6144;
  localparam logic [15:0] SOCIAL_RST   = 16'd6144;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_MOVE  = 2'd2,
    FN_EVAL  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CR_INERTIA  = 3'd0,
    CR_PERSONAL = 3'd1,
    CR_SOCIAL   = 3'd2,
    CR_MIN_X    = 3'd3,
    CR_MAX_X    = 3'd4,
    CR_MIN_Y    = 3'd5,
    CR_MAX_Y    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_SUM,
    ST_POS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bf;
  } entry_t;

  function automatic logic [31:0] sat32(input logic [39:0] x);
    if (x[39:31] == {9{x[39]}}) begin
      return x[31:0];
    end else if (x[39]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

[hw/rtl/particle_swarm_update_2d_unit.sv]
// Particle swarm update unit: particle table, velocity/position update and best tracking.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | func, particle, load values, fitness, rand factors
//  out     | out_valid / out_stall | particle, position, velocity, swarm best, flags
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One transaction at a time. Clear and load skip fetch; in move, after fetch, the
//  per-axis multiply, sum and clamp steps run twice on one shared datapath.
//  The particle memory is read at acceptance and written back at finish except on clear.
//  The finish cycle holds while the output register is full and stalled; the next
//  transaction is accepted once the result sits in the output register.
//  Synchronous active-low reset; particle memory contents are undefined until loaded.
`include "particle_swarm_update_2d_unit_defines.svh"

module particle_swarm_update_2d_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_particle,
  input  logic [31:0] in_load_pos_x,
  input  logic [31:0] in_load_pos_y,
  input  logic [31:0] in_load_vel_x,
  input  logic [31:0] in_load_vel_y,
  input  logic [31:0] in_fitness,
  input  logic [15:0] in_rand_one,
  input  logic [15:0] in_rand_two,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_result_particle,
  output logic [31:0] out_new_pos_x,
  output logic [31:0] out_new_pos_y,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic [31:0] out_swarm_best_x,
  output logic [31:0] out_swarm_best_y,
  output logic [31:0] out_swarm_best_fitness,
  output logic        out_personal_improved,
  output logic        out_swarm_improved,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  psu2d_pkg::state_t state_r, state_nxt;
  logic              ax_r, ax_nxt;

  psu2d_pkg::func_t  func_r;
  logic [psu2d_pkg::PIDX_W-1:0] idx_r;
  logic [31:0]       fit_r;
  logic [15:0]       r1_r, r2_r;

  psu2d_pkg::entry_t cur_r, cur_nxt;
  psu2d_pkg::entry_t rd_data_r;
  psu2d_pkg::entry_t wr_entry;
  psu2d_pkg::entry_t mem [psu2d_pkg::PARTICLE_COUNT];

  logic [15:0]        g1_r, g2_r;
  logic [31:0]        gp1, gp2;
  logic signed [48:0] prod_w_r, prod_w_nxt;
  logic signed [49:0] prod1_r, prod1_nxt, prod2_r, prod2_nxt;
  logic [31:0]        nv_r, nv_nxt;

  logic [15:0] inertia_r, personal_r, social_r;
  logic [31:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [31:0] gbest_x_r, gbest_y_r, gbest_fit_r;
  logic [31:0] gbest_x_nxt, gbest_y_nxt, gbest_fit_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_part_r;
  logic [31:0] out_px_r, out_py_r, out_vx_r, out_vy_r;
  logic        out_pimp_r, out_simp_r;

  logic in_accept, cfg_accept, out_free, finish_fire, item_ok, show, mem_we;

  logic [31:0] a_p, a_v, a_b, a_g, a_lo, a_hi;
  logic signed [32:0] diff1, diff2;
  logic signed [48:0] term_w;
  logic signed [49:0] term_1, term_2;
  logic [39:0]        sum40, pos40;
  logic [31:0]        np, np_f, nv_f;
  logic signed [32:0] half_t, half_s, neg_t;
  logic               lo_hit, hi_hit;
  logic               pimp, simp;

  // control outputs
  always_comb begin
    in_stall    = (state_r != psu2d_pkg::ST_IDLE);
    in_accept   = in_valid && !in_stall;
    cfg_ready   = 1'b1;
    cfg_accept  = cfg_valid && cfg_ready;
    out_free    = !out_valid_r || !out_stall;
    finish_fire = (state_r == psu2d_pkg::ST_FINISH) && out_free;
    item_ok     = ({1'b0, idx_r} < (psu2d_pkg::PIDX_W + 1)'(psu2d_pkg::PARTICLE_COUNT));
    show        = item_ok && (func_r != psu2d_pkg::FN_CLEAR);
    mem_we      = finish_fire && show;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psu2d_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (psu2d_pkg::func_t'(in_func) == psu2d_pkg::FN_MOVE ||
              psu2d_pkg::func_t'(in_func) == psu2d_pkg::FN_EVAL) begin
            state_nxt = psu2d_pkg::ST_FETCH;
          end else begin
            state_nxt = psu2d_pkg::ST_FINISH;
          end
        end
      end
      psu2d_pkg::ST_FETCH: begin
        if (func_r == psu2d_pkg::FN_MOVE && item_ok) begin
          state_nxt = psu2d_pkg::ST_MUL;
        end else begin
          state_nxt = psu2d_pkg::ST_FINISH;
        end
      end
      psu2d_pkg::ST_MUL: state_nxt = psu2d_pkg::ST_SUM;
      psu2d_pkg::ST_SUM: state_nxt = psu2d_pkg::ST_POS;
      psu2d_pkg::ST_POS: begin
        state_nxt = ax_r ? psu2d_pkg::ST_FINISH : psu2d_pkg::ST_MUL;
      end
      psu2d_pkg::ST_FINISH: begin
        if (finish_fire) begin
          state_nxt = psu2d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psu2d_pkg::ST_IDLE;
    endcase
  end

  // axis operand select
  always_comb begin
    a_p  = ax_r ? cur_r.py : cur_r.px;
    a_v  = ax_r ? cur_r.vy : cur_r.vx;
    a_b  = ax_r ? cur_r.by : cur_r.bx;
    a_g  = ax_r ? gbest_y_r : gbest_x_r;
    a_lo = ax_r ? min_y_r : min_x_r;
    a_hi = ax_r ? max_y_r : max_x_r;
  end

  // move datapath
  always_comb begin
    gp1 = personal_r * r1_r;
    gp2 = social_r * r2_r;

    diff1      = $signed({a_b[31], a_b}) - $signed({a_p[31], a_p});
    diff2      = $signed({a_g[31], a_g}) - $signed({a_p[31], a_p});
    prod_w_nxt = $signed({1'b0, inertia_r}) * $signed(a_v);
    prod1_nxt  = $signed({1'b0, g1_r}) * diff1;
    prod2_nxt  = $signed({1'b0, g2_r}) * diff2;

    term_w = prod_w_r >>> 12;
    term_1 = prod1_r >>> 12;
    term_2 = prod2_r >>> 12;
    sum40  = term_w[39:0] + term_1[39:0] + term_2[39:0];
    nv_nxt = psu2d_pkg::sat32(sum40);

    pos40  = {{8{a_p[31]}}, a_p} + {{8{nv_r[31]}}, nv_r};
    np     = psu2d_pkg::sat32(pos40);
    lo_hit = $signed(np) < $signed(a_lo);
    hi_hit = $signed(np) > $signed(a_hi);
    half_t = $signed({nv_r[31], nv_r}) + $signed({32'd0, nv_r[31]});
    half_s = half_t >>> 1;
    neg_t  = 33'sd0 - half_s;
    np_f   = lo_hit ? a_lo : (hi_hit ? a_hi : np);
    nv_f   = (lo_hit || hi_hit) ? neg_t[31:0] : nv_r;
  end

  // working entry
  always_comb begin
    cur_nxt = cur_r;
    ax_nxt  = ax_r;
    if (in_accept) begin
      cur_nxt.px = in_load_pos_x;
      cur_nxt.py = in_load_pos_y;
      cur_nxt.vx = in_load_vel_x;
      cur_nxt.vy = in_load_vel_y;
      cur_nxt.bx = in_load_pos_x;
      cur_nxt.by = in_load_pos_y;
      cur_nxt.bf = in_fitness;
      ax_nxt     = 1'b0;
    end else if (state_r == psu2d_pkg::ST_FETCH) begin
      cur_nxt = rd_data_r;
    end else if (state_r == psu2d_pkg::ST_POS) begin
      ax_nxt = 1'b1;
      if (ax_r) begin
        cur_nxt.py = np_f;
        cur_nxt.vy = nv_f;
      end else begin
        cur_nxt.px = np_f;
        cur_nxt.vx = nv_f;
      end
    end
  end

  // finish: best update and result
  always_comb begin
    wr_entry      = cur_r;
    pimp          = 1'b0;
    simp          = 1'b0;
    gbest_x_nxt   = gbest_x_r;
    gbest_y_nxt   = gbest_y_r;
    gbest_fit_nxt = gbest_fit_r;
    case (func_r)
      psu2d_pkg::FN_CLEAR: gbest_fit_nxt = psu2d_pkg::NO_BEST;
      psu2d_pkg::FN_LOAD: begin
        simp = item_ok && ($signed(fit_r) < $signed(gbest_fit_r));
      end
      psu2d_pkg::FN_EVAL: begin
        pimp = item_ok && ($signed(fit_r) < $signed(cur_r.bf));
        simp = pimp && ($signed(fit_r) < $signed(gbest_fit_r));
        if (pimp) begin
          wr_entry.bx = cur_r.px;
          wr_entry.by = cur_r.py;
          wr_entry.bf = fit_r;
        end
      end
      default: ;
    endcase
    if (simp) begin
      gbest_x_nxt   = cur_r.px;
      gbest_y_nxt   = cur_r.py;
      gbest_fit_nxt = fit_r;
    end
    out_valid_nxt = finish_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psu2d_pkg::ST_IDLE;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
      gbest_x_r   <= '0;
      gbest_y_r   <= '0;
      gbest_fit_r <= psu2d_pkg::NO_BEST;
      inertia_r   <= psu2d_pkg::INERTIA_RST;
      personal_r  <= psu2d_pkg::PERSONAL_RST;
      social_r    <= psu2d_pkg::SOCIAL_RST;
      min_x_r     <= psu2d_pkg::POS_MIN_RST;
      max_x_r     <= psu2d_pkg::POS_MAX_RST;
      min_y_r     <= psu2d_pkg::POS_MIN_RST;
      max_y_r     <= psu2d_pkg::POS_MAX_RST;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish_fire) begin
        gbest_x_r   <= gbest_x_nxt;
        gbest_y_r   <= gbest_y_nxt;
        gbest_fit_r <= gbest_fit_nxt;
      end
      if (cfg_accept) begin
        unique case (psu2d_pkg::cfg_reg_t'(cfg_index))
          psu2d_pkg::CR_INERTIA:  inertia_r  <= cfg_data[15:0];
          psu2d_pkg::CR_PERSONAL: personal_r <= cfg_data[15:0];
          psu2d_pkg::CR_SOCIAL:   social_r   <= cfg_data[15:0];
          psu2d_pkg::CR_MIN_X:    min_x_r    <= cfg_data;
          psu2d_pkg::CR_MAX_X:    max_x_r    <= cfg_data;
          psu2d_pkg::CR_MIN_Y:    min_y_r    <= cfg_data;
          psu2d_pkg::CR_MAX_Y:    max_y_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // transaction and datapath payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (in_accept) begin
      func_r <= psu2d_pkg::func_t'(in_func);
      idx_r  <= in_particle;
      fit_r  <= in_fitness;
      r1_r   <= in_rand_one;
      r2_r   <= in_rand_two;
    end
    if (state_r == psu2d_pkg::ST_FETCH) begin
      g1_r <= gp1[31:16];
      g2_r <= gp2[31:16];
    end
    if (state_r == psu2d_pkg::ST_MUL) begin
      prod_w_r <= prod_w_nxt;
      prod1_r  <= prod1_nxt;
      prod2_r  <= prod2_nxt;
    end
    if (state_r == psu2d_pkg::ST_SUM) begin
      nv_r <= nv_nxt;
    end
    if (finish_fire) begin
      out_part_r <= idx_r;
      out_px_r   <= show ? wr_entry.px : '0;
      out_py_r   <= show ? wr_entry.py : '0;
      out_vx_r   <= show ? wr_entry.vx : '0;
      out_vy_r   <= show ? wr_entry.vy : '0;
      out_pimp_r <= pimp;
      out_simp_r <= simp;
    end
  end

  // particle memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= wr_entry;
    end
    if (in_accept) begin
      rd_data_r <= mem[in_particle];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_particle    = out_part_r;
  assign out_new_pos_x          = out_px_r;
  assign out_new_pos_y          = out_py_r;
  assign out_new_vel_x          = out_vx_r;
  assign out_new_vel_y          = out_vy_r;
  assign out_swarm_best_x       = gbest_x_r;
  assign out_swarm_best_y       = gbest_y_r;
  assign out_swarm_best_fitness = gbest_fit_r;
  assign out_personal_improved  = out_pimp_r;
  assign out_swarm_improved     = out_simp_r;

  `PSU2D_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, state_r != psu2d_pkg::ST_IDLE, "accepted transaction left the unit idle")
  `PSU2D_ASSERT_IMPLY(a_fetch_axis, clk, rst_n, state_r == psu2d_pkg::ST_FETCH, !ax_r, "axis select not on x at fetch")
  `PSU2D_ASSERT_NEXT(a_best_hold, clk, rst_n, out_valid_r && out_stall, gbest_fit_r == $past(gbest_fit_r) && gbest_x_r == $past(gbest_x_r), "swarm best changed under a held result")

endmodule
